// ===== rtl/core/bqc_pkg.sv =====
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared types and constants of the cascaded biquad IIR filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bqc_pkg;

    localparam int COEF_W     = 16;   // signed coefficient width
    localparam int IN_W       = 24;   // sample_in width
    localparam int OUT_W      = 32;   // sample_out width
    localparam int MAX_SEC    = 3;    // sections that have config registers
    localparam int MAX_SEC_W  = 2;
    localparam int NUM_W      = 48;   // b0, b1, b2 packed
    localparam int DEN_W      = 33;   // a0, a1 packed, Q15 flag on top
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int NUM_REGS   = 2 * MAX_SEC;
    localparam int NUM_LANES  = 5;
    localparam int Q15_BIT    = 32;

    // product lanes
    localparam int LANE_B0 = 0;
    localparam int LANE_B1 = 1;
    localparam int LANE_B2 = 2;
    localparam int LANE_A0 = 3;
    localparam int LANE_A1 = 4;

    localparam logic [NUM_W-1:0] NUM_RST [MAX_SEC] = '{
        48'd62819997858082, 48'd83856725199940, 48'd116000493103488
    };
    localparam logic [DEN_W-1:0] DEN_RST [MAX_SEC] = '{
        33'd3460017192, 33'd7152323611, 33'd6610198550
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL,
        S_UPD,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;   // clear accumulator, take coefficient
        logic step;   // one coefficient bit
        logic last;   // sign bit of the coefficient: subtract
        logic q15;    // shift by one less
    } t_lane_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/bqc_if.sv =====
// ----------------------------------------------------------------------------
// bqc_if
// Valid/ready channels of the biquad filter: samples in, samples out, config.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqc_in_if;
    import bqc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] sample_in;
    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqc_out_if;
    import bqc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] sample_out;
    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface bqc_cfg_if;
    import bqc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bqc_lane.sv =====
// ----------------------------------------------------------------------------
// bqc_lane
// Bit-serial shift-add multiplier: one coefficient bit per cycle against a
// shared, left-shifting multiplicand, then the floor shift to state width.
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_lane #(
    parameter int STATE_WIDTH    = 48,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                                      i_clk,
    input  wire bqc_pkg::t_lane_ctl                        i_ctl,
    input  wire logic [bqc_pkg::COEF_W-1:0]                i_coef,
    input  wire logic signed [STATE_WIDTH+bqc_pkg::COEF_W-1:0] i_mcand,
    output logic signed [STATE_WIDTH-1:0]                  o_prod
);
    import bqc_pkg::*;

    localparam int PW = STATE_WIDTH + COEF_W;

    logic [COEF_W-1:0]    r_coef;
    logic signed [PW-1:0] r_acc;
    logic signed [PW-1:0] w_shr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_coef <= i_coef;
            r_acc  <= '0;
        end else if (i_ctl.step) begin
            r_coef <= r_coef >> 1;
            if (r_coef[0]) begin
                // two's complement: the top coefficient bit weighs negative
                r_acc <= i_ctl.last ? (r_acc - i_mcand) : (r_acc + i_mcand);
            end
        end
    end

    assign w_shr  = i_ctl.q15 ? (r_acc >>> (COEF_FRAC_BITS - 1)) : (r_acc >>> COEF_FRAC_BITS);
    assign o_prod = w_shr[STATE_WIDTH-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/biquad_cascade_iir_q16_top.sv =====
// ----------------------------------------------------------------------------
// biquad_cascade_iir_q16_top
// Cascade of second-order IIR sections in Q16 or Q15 fixed point, saturated output.
// ----------------------------------------------------------------------------
// One sample is worked on at a time. Each section runs S_LOAD to form
// w = x + z1, then S_MUL, in which five bit-serial multiplier lanes step
// through the COEF_W = 16 coefficient bits in parallel, then S_UPD to
// update the delays. After the last section, S_FIN writes the result into
// the output register, and the input is ready again in the cycle in which
// the result is offered. The result sits in an output register, so a new
// sample may be accepted while it waits; a finished sample waits only if
// the previous one is still untaken. Config writes are ready whenever out
// of reset and must be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_cascade_iir_q16_top #(
    parameter int SECTIONS       = 3,
    parameter int COEF_FRAC_BITS = 16,
    parameter int STATE_WIDTH    = 48
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    bqc_in_if.sink        i_in,
    bqc_out_if.source     o_out,
    bqc_cfg_if.sink       i_cfg
);
    import bqc_pkg::*;

    localparam int SW    = STATE_WIDTH;
    localparam int PW    = SW + COEF_W;
    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int CNT_W = $clog2(COEF_W);

    t_state r_state, n_state;

    logic [NUM_W-1:0] r_num [MAX_SEC];
    logic [DEN_W-1:0] r_den [MAX_SEC];

    logic signed [SW-1:0] r_z1 [SECTIONS];
    logic signed [SW-1:0] r_z2 [SECTIONS];
    logic signed [SW-1:0] r_z3 [SECTIONS];
    logic signed [SW-1:0] r_z4 [SECTIONS];

    logic [SEC_W-1:0]        r_sec;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [SW-1:0]    r_x;
    logic signed [PW-1:0]    r_mcand;
    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_data;

    t_lane_ctl            w_ctl;
    logic                 w_in_ready;
    logic                 w_out_write;
    logic                 w_last_bit;
    logic                 w_last_sec;
    logic                 w_slot_free;
    logic [MAX_SEC_W-1:0] w_cidx;
    logic signed [SW-1:0] w_w;
    logic signed [SW-1:0] w_y;
    logic [COEF_W-1:0]    w_coef [NUM_LANES];
    logic signed [SW-1:0] w_prod [NUM_LANES];
    logic signed [OUT_W-1:0] w_sat;
    logic [MAX_SEC_W-1:0] w_cfg_sec;

    assign w_cidx      = MAX_SEC_W'(r_sec);
    assign w_last_bit  = (r_cnt == CNT_W'(COEF_W - 1));
    assign w_last_sec  = (r_sec == SEC_W'(SECTIONS - 1));
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_w         = r_x + r_z1[r_sec];
    assign w_y         = w_prod[LANE_B0] + r_z4[r_sec];

    assign w_coef[LANE_B0] = r_num[w_cidx][COEF_W-1:0];
    assign w_coef[LANE_B1] = r_num[w_cidx][2*COEF_W-1:COEF_W];
    assign w_coef[LANE_B2] = r_num[w_cidx][3*COEF_W-1:2*COEF_W];
    assign w_coef[LANE_A0] = r_den[w_cidx][COEF_W-1:0];
    assign w_coef[LANE_A1] = r_den[w_cidx][2*COEF_W-1:COEF_W];

    // saturate the last section's output to 32 bits
    always_comb begin
        if (r_x[SW-1:OUT_W-1] == {(SW-OUT_W+1){r_x[SW-1]}}) begin
            w_sat = r_x[OUT_W-1:0];
        end else if (r_x[SW-1]) begin
            w_sat = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_in_ready  = 1'b0;
        w_out_write = 1'b0;
        w_ctl.load  = 1'b0;
        w_ctl.step  = 1'b0;
        w_ctl.last  = w_last_bit;
        w_ctl.q15   = r_den[w_cidx][Q15_BIT];
        unique case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                w_ctl.load = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                w_ctl.step = 1'b1;
                if (w_last_bit) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = w_last_sec ? S_FIN : S_LOAD;
            end
            S_FIN: begin
                if (w_slot_free) begin
                    w_out_write = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // no item is taken while reset is held
    assign i_in.ready = w_in_ready && i_rst_n;

    // section counter and output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_IDLE) begin
                r_sec <= '0;
            end else if (r_state == S_UPD && !w_last_sec) begin
                r_sec <= r_sec + 1'b1;
            end
            if (w_out_write) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_write) begin
            r_out_data <= w_sat;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_data;

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_x <= {{(SW-IN_W){i_in.sample_in[IN_W-1]}}, i_in.sample_in};
            end
            S_LOAD: begin
                r_mcand <= {{COEF_W{w_w[SW-1]}}, w_w};
                r_cnt   <= '0;
            end
            S_MUL: begin
                r_mcand <= r_mcand <<< 1;
                r_cnt   <= r_cnt + 1'b1;
            end
            S_UPD: begin
                r_x <= w_y;
            end
            default: begin
            end
        endcase
    end

    // delay line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SECTIONS; j++) begin
                r_z1[j] <= '0;
                r_z2[j] <= '0;
                r_z3[j] <= '0;
                r_z4[j] <= '0;
            end
        end else if (r_state == S_UPD) begin
            r_z1[r_sec] <= w_prod[LANE_A0] + r_z2[r_sec];
            r_z4[r_sec] <= w_prod[LANE_B1] + r_z3[r_sec];
            r_z2[r_sec] <= w_prod[LANE_A1];
            r_z3[r_sec] <= w_prod[LANE_B2];
        end
    end

    // configuration registers; out-of-range indexes are dropped
    assign i_cfg.ready = i_rst_n;
    assign w_cfg_sec   = i_cfg.reg_index[CFG_IDX_W-1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < MAX_SEC; j++) begin
                r_num[j] <= NUM_RST[j];
                r_den[j] <= DEN_RST[j];
            end
        end else if (i_cfg.valid && (i_cfg.reg_index < CFG_IDX_W'(NUM_REGS))) begin
            if (i_cfg.reg_index[0]) begin
                r_den[w_cfg_sec] <= i_cfg.wr_data[DEN_W-1:0];
            end else begin
                r_num[w_cfg_sec] <= i_cfg.wr_data[NUM_W-1:0];
            end
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        bqc_lane #(
            .STATE_WIDTH    (STATE_WIDTH),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_coef  (w_coef[g]),
            .i_mcand (r_mcand),
            .o_prod  (w_prod[g])
        );
    end

endmodule

`default_nettype wire

// ===== rtl/core/bqc_checker.sv =====
// ----------------------------------------------------------------------------
// bqc_checker
// Port-level checks of the biquad filter top level, bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module bqc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        i_in_ready,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [bqc_pkg::OUT_W-1:0]   i_out_data
);
    import bqc_pkg::*;

    // a stalled item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("output item changed while stalled");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    // a result only follows a stretch of work
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without work in progress");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind biquad_cascade_iir_q16_top bqc_checker u_bqc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.sample_out)
);

`default_nettype wire

// ===== dv/biquad_cascade_iir_q16_top_tb.sv =====
// ----------------------------------------------------------------------------
// biquad_cascade_iir_q16_top_tb
// Self-checking bench for the three-section Q16 biquad cascade. A directed
// table and random phases drive samples and coefficient writes under mixed
// backpressure. A bit-accurate filter model in the bench predicts every
// output sample the table gives no value for; each output is compared in order.
// ----------------------------------------------------------------------------
module biquad_cascade_iir_q16_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bqc_pkg::*;

    localparam int N_SEC     = 3;
    localparam int FRAC_BITS = 16;
    localparam int STATE_W   = 48;

    typedef logic signed [STATE_W-1:0] acc_t;
    typedef logic signed [IN_W-1:0]    sample_t;
    typedef logic signed [OUT_W-1:0]   result_t;

    localparam acc_t OUT_MAX = 48'sd2147483647;
    localparam acc_t OUT_MIN = -48'sd2147483648;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEC0_NUM,
        REG_SEC0_DEN,
        REG_SEC1_NUM,
        REG_SEC1_DEN,
        REG_SEC2_NUM,
        REG_SEC2_DEN,
        REG_SPARE6,
        REG_SPARE7
    } reg_idx_e;

    typedef enum bit {ROW_SAMPLE, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        reg_idx_e              idx;
        logic [CFG_DATA_W-1:0] data;
        sample_t               x;
        bit                    typed;
        result_t               exp_v;
    } dir_row_t;

    localparam int NUM_DIRECTED = 50;

    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        // reset coefficients, zero state
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh000000, 1'b1, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh000000, 1'b1, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh7FFFFF, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh800000, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh000001, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'shFFFFFF, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh555555, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'shAAAAAA, 1'b0, 32'sh0},
        // all coefficients zero: delays flush out after two items
        '{ROW_CFG,    REG_SEC0_NUM, 48'h0, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC0_DEN, 48'h0, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC1_NUM, 48'h0, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC1_DEN, 48'h0, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC2_NUM, 48'h0, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC2_DEN, 48'h0, 24'sh0, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh7FFFFF, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh800000, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sd12345, 1'b1, 32'sh0},
        // b0 = -1.0 in Q15, rest zero: each section negates
        '{ROW_CFG,    REG_SEC0_NUM, 48'h0000_0000_8000, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC0_DEN, 48'h0001_0000_0000, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC1_NUM, 48'h0000_0000_8000, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC1_DEN, 48'h0001_0000_0000, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC2_NUM, 48'h0000_0000_8000, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC2_DEN, 48'h0001_0000_0000, 24'sh0, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh7FFFFF, 1'b1, 32'shFF80_0001},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh800000, 1'b1, 32'sh0080_0000},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh000000, 1'b1, 32'sh0},
        // writes past the last register are dropped
        '{ROW_CFG,    REG_SPARE6,   48'hFFFF_FFFF_FFFF, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SPARE7,   48'h1234_5678_9ABC, 24'sh0, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sd5, 1'b1, 32'shFFFF_FFFB},
        // denominator bits above 32 are dropped
        '{ROW_CFG,    REG_SEC0_DEN, 48'hFFFF_0000_0000, 24'sh0, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'shFFFFF9, 1'b1, 32'sh0000_0007},
        // largest coefficients, Q15: runs away into saturation
        '{ROW_CFG,    REG_SEC0_NUM, 48'h7FFF_7FFF_7FFF, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC0_DEN, 48'h0001_7FFF_7FFF, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC1_NUM, 48'h7FFF_7FFF_7FFF, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC1_DEN, 48'h0001_7FFF_7FFF, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC2_NUM, 48'h7FFF_7FFF_7FFF, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC2_DEN, 48'h0001_7FFF_7FFF, 24'sh0, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh7FFFFF, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh7FFFFF, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh7FFFFF, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh800000, 1'b0, 32'sh0},
        // most negative coefficients, Q16
        '{ROW_CFG,    REG_SEC0_NUM, 48'h8000_8000_8000, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC0_DEN, 48'h0000_8000_8000, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC1_NUM, 48'h8000_8000_8000, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC1_DEN, 48'h0000_8000_8000, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC2_NUM, 48'h8000_8000_8000, 24'sh0, 1'b0, 32'sh0},
        '{ROW_CFG,    REG_SEC2_DEN, 48'h0000_8000_8000, 24'sh0, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh800000, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh7FFFFF, 1'b0, 32'sh0},
        '{ROW_SAMPLE, REG_SEC0_NUM, 48'h0, 24'sh000000, 1'b0, 32'sh0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    bqc_in_if  in_if ();
    bqc_out_if out_if ();
    bqc_cfg_if cfg_if ();

    biquad_cascade_iir_q16_top #(
        .SECTIONS      (N_SEC),
        .COEF_FRAC_BITS(FRAC_BITS),
        .STATE_WIDTH   (STATE_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // filter model state
    logic [NUM_W-1:0] num_q [MAX_SEC];
    logic [DEN_W-1:0] den_q [MAX_SEC];
    acc_t             z1_q [MAX_SEC];
    acc_t             z2_q [MAX_SEC];
    acc_t             z3_q [MAX_SEC];
    acc_t             z4_q [MAX_SEC];

    result_t pending_outputs [$];
    result_t expected_out;

    int errors        = 0;
    int samples_sent  = 0;
    int cfg_writes    = 0;
    int saturated     = 0;
    int results_seen  = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // exact product, floored by the section shift, wrapped to the state width
    function automatic acc_t scaled_product(input acc_t w, input logic [COEF_W-1:0] c,
                                            input bit q15);
        logic signed [63:0] wx;
        logic signed [63:0] cx;
        logic signed [63:0] p;
        wx = w;
        cx = $signed(c);
        p  = wx * cx;
        p  = p >>> (FRAC_BITS - int'(q15));
        return p[STATE_W-1:0];
    endfunction

    function automatic result_t filter_sample(input sample_t x);
        acc_t v;
        acc_t w;
        acc_t y;
        bit   q15;
        int   s;
        v = x;
        for (s = 0; s < N_SEC; s++) begin
            q15 = den_q[s][Q15_BIT];
            w = v + z1_q[s];
            y = scaled_product(w, num_q[s][15:0], q15) + z4_q[s];
            z1_q[s] = scaled_product(w, den_q[s][15:0], q15) + z2_q[s];
            z4_q[s] = scaled_product(w, num_q[s][31:16], q15) + z3_q[s];
            z2_q[s] = scaled_product(w, den_q[s][31:16], q15);
            z3_q[s] = scaled_product(w, num_q[s][47:32], q15);
            v = y;
        end
        if (v > OUT_MAX) begin
            v = OUT_MAX;
            saturated++;
        end else if (v < OUT_MIN) begin
            v = OUT_MIN;
            saturated++;
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic void apply_reg_write(input reg_idx_e idx,
                                            input logic [CFG_DATA_W-1:0] data);
        if (int'(idx) < NUM_REGS) begin
            if (idx[0] == 1'b0) begin
                num_q[idx >> 1] = data[NUM_W-1:0];
            end else begin
                den_q[idx >> 1] = data[DEN_W-1:0];
            end
        end
    endfunction

    task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wr_data   <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        apply_reg_write(idx, data);
        cfg_writes++;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // returns at the accepting edge so a back-to-back item keeps valid high
    task automatic send_sample(input sample_t x, input bit typed, input result_t typed_v);
        result_t predicted;
        int      gap;
        @(negedge i_clk);
        gap = 0;
        if (send_idle_pct > 0 && $urandom_range(99) < 4) begin
            gap = $urandom_range(80, 1);
        end
        while (gap > 0 || $urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            if (gap > 0) begin
                gap--;
            end
            @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.sample_in <= x;
        do @(posedge i_clk); while (!in_if.ready);
        predicted = filter_sample(x);
        pending_outputs.push_back(typed ? typed_v : predicted);
        samples_sent++;
    endtask

    // quiet the input and wait for the filter to drain before a config change
    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_outputs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // output side: random stalls plus one long hold once traffic is flowing
    initial begin
        int hold_left;
        bit held;
        hold_left    = 0;
        held         = 1'b0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 300) begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (pending_outputs.size() == 0) begin
                errors++;
                $display("%0t: sample_out with none pending, expected none actual %0d",
                         $time, out_if.sample_out);
            end else begin
                expected_out = pending_outputs.pop_front();
                if (out_if.sample_out !== expected_out) begin
                    errors++;
                    $display("%0t: sample_out expected %0d actual %0d",
                             $time, expected_out, out_if.sample_out);
                end
            end
        end
    end

    initial begin
        #800_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int                    i;
        int                    phase;
        int                    n;
        int                    r;
        sample_t               x;
        logic [CFG_DATA_W-1:0] d;

        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.sample_in  = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.reg_index = REG_SEC0_NUM;
        cfg_if.wr_data   = '0;
        for (r = 0; r < MAX_SEC; r++) begin
            num_q[r] = NUM_RST[r];
            den_q[r] = DEN_RST[r];
            z1_q[r]  = '0;
            z2_q[r]  = '0;
            z3_q[r]  = '0;
            z4_q[r]  = '0;
        end
        send_idle_pct = 23;
        recv_idle_pct = 74;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        for (i = 0; i < NUM_DIRECTED; i++) begin
            if (DIRECTED[i].kind == ROW_CFG) begin
                settle();
                write_reg(DIRECTED[i].idx, DIRECTED[i].data);
            end else begin
                send_sample(DIRECTED[i].x, DIRECTED[i].typed, DIRECTED[i].exp_v);
            end
        end

        // phases: reset design, arbitrary coefficients, mild feedback;
        // idle mix changes every two phases
        for (phase = 0; phase < 6; phase++) begin
            settle();
            case (phase / 2)
                0: begin
                    send_idle_pct = 23;
                    recv_idle_pct = 74;
                end
                1: begin
                    send_idle_pct = 74;
                    recv_idle_pct = 23;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (phase % 3)
                0: begin
                    for (r = 0; r < MAX_SEC; r++) begin
                        write_reg(reg_idx_e'(2 * r), NUM_RST[r]);
                        write_reg(reg_idx_e'(2 * r + 1), CFG_DATA_W'(DEN_RST[r]));
                    end
                end
                1: begin
                    write_reg(REG_SPARE6, CFG_DATA_W'({$urandom(), $urandom()}));
                    write_reg(REG_SPARE7, CFG_DATA_W'({$urandom(), $urandom()}));
                    for (r = 0; r < NUM_REGS; r++) begin
                        write_reg(reg_idx_e'(r), CFG_DATA_W'({$urandom(), $urandom()}));
                    end
                end
                default: begin
                    for (r = 0; r < MAX_SEC; r++) begin
                        write_reg(reg_idx_e'(2 * r), CFG_DATA_W'({$urandom(), $urandom()}));
                        // |a0| + |a1| below one keeps the poles inside
                        d = {15'($urandom()), 1'($urandom()),
                             16'(int'($urandom_range(32766)) - 16383),
                             16'(int'($urandom_range(32766)) - 16383)};
                        write_reg(reg_idx_e'(2 * r + 1), d);
                    end
                end
            endcase
            for (n = 0; n < 100; n++) begin
                case ($urandom_range(9))
                    0: x = $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
                    1, 2: x = IN_W'(int'($urandom_range(512)) - 256);
                    default: x = IN_W'($urandom());
                endcase
                send_sample(x, 1'b0, '0);
            end
        end

        settle();
        repeat (60) @(negedge i_clk);
        $display("%0d samples filtered, %0d saturated, across %0d coefficient writes",
                 samples_sent, saturated, cfg_writes);
        $display("three idle mixes and a 400-cycle output hold were exercised");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
